[design/apw_pkg.sv]
// Package for the average pooling window mean block: field widths, register
// indexes, microcode word type, action and jump codes and the control program.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package apw_pkg;

    // Fixed field widths
    localparam int OP_W       = 1;
    localparam int IDX_W      = 6;   // row / col of an item
    localparam int CH_W       = 4;
    localparam int DATA_W     = 16;  // sample and average fields
    localparam int SIZE_W     = 6;   // in_height, in_width
    localparam int WIN_W      = 4;   // window and stride sizes
    localparam int PAD_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;
    localparam int CNT_W      = 8;   // clipped sample count, at most 15 * 15
    localparam int PROD_W     = IDX_W + WIN_W;
    localparam int START_W    = PROD_W + 1;
    localparam int END_W      = START_W + 1;

    // Item opcodes
    localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OP_W-1:0] OP_POOL = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ROWS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COLS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_ROWS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_COLS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_TOP     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_LEFT    = 3'd7;

    // Datapath actions
    localparam int ACT_W = 4;
    localparam logic [ACT_W-1:0] ACT_NOP       = 4'd0;
    localparam logic [ACT_W-1:0] ACT_ACCEPT    = 4'd1;
    localparam logic [ACT_W-1:0] ACT_START     = 4'd2;
    localparam logic [ACT_W-1:0] ACT_CLIP      = 4'd3;
    localparam logic [ACT_W-1:0] ACT_INIT      = 4'd4;
    localparam logic [ACT_W-1:0] ACT_READ      = 4'd5;
    localparam logic [ACT_W-1:0] ACT_DIV_INIT  = 4'd6;
    localparam logic [ACT_W-1:0] ACT_DIV_STEP  = 4'd7;
    localparam logic [ACT_W-1:0] ACT_PUT_AVG   = 4'd8;
    localparam logic [ACT_W-1:0] ACT_PUT_EMPTY = 4'd9;

    // Jump conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] COND_NEVER    = 3'd0;
    localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd1;
    localparam logic [COND_W-1:0] COND_POOL     = 3'd2;
    localparam logic [COND_W-1:0] COND_EMPTY    = 3'd3;
    localparam logic [COND_W-1:0] COND_LAST     = 3'd4;
    localparam logic [COND_W-1:0] COND_DIV_LAST = 3'd5;
    localparam logic [COND_W-1:0] COND_OUT_FREE = 3'd6;

    // Program steps
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] STEP_IDLE      = 4'd0;
    localparam logic [PC_W-1:0] STEP_START     = 4'd1;
    localparam logic [PC_W-1:0] STEP_CLIP      = 4'd2;
    localparam logic [PC_W-1:0] STEP_INIT      = 4'd3;
    localparam logic [PC_W-1:0] STEP_READ      = 4'd4;
    localparam logic [PC_W-1:0] STEP_DRAIN     = 4'd5;
    localparam logic [PC_W-1:0] STEP_DIV_INIT  = 4'd6;
    localparam logic [PC_W-1:0] STEP_DIV       = 4'd7;
    localparam logic [PC_W-1:0] STEP_PUT_AVG   = 4'd8;
    localparam logic [PC_W-1:0] STEP_PUT_EMPTY = 4'd9;

    // One control word: action, jump condition and target, and whether a
    // step repeats while its condition is false
    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
        logic              stay;
    } ucode_t;

    // Result of clipping one window axis
    typedef struct packed {
        logic [SIZE_W-1:0] first;
        logic [SIZE_W-1:0] last;
        logic [WIN_W-1:0]  n;
    } axis_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{act: ACT_NOP, cond: COND_ALWAYS, target: STEP_IDLE, stay: 1'b0};
        unique case (pc)
            STEP_IDLE:
                w = '{act: ACT_ACCEPT, cond: COND_POOL, target: STEP_START, stay: 1'b1};
            STEP_START:
                w = '{act: ACT_START, cond: COND_NEVER, target: STEP_IDLE, stay: 1'b0};
            STEP_CLIP:
                w = '{act: ACT_CLIP, cond: COND_NEVER, target: STEP_IDLE, stay: 1'b0};
            STEP_INIT:
                w = '{act: ACT_INIT, cond: COND_EMPTY, target: STEP_PUT_EMPTY, stay: 1'b0};
            STEP_READ:
                w = '{act: ACT_READ, cond: COND_LAST, target: STEP_DRAIN, stay: 1'b1};
            STEP_DRAIN:
                w = '{act: ACT_NOP, cond: COND_NEVER, target: STEP_IDLE, stay: 1'b0};
            STEP_DIV_INIT:
                w = '{act: ACT_DIV_INIT, cond: COND_NEVER, target: STEP_IDLE, stay: 1'b0};
            STEP_DIV:
                w = '{act: ACT_DIV_STEP, cond: COND_DIV_LAST, target: STEP_PUT_AVG,
                      stay: 1'b1};
            STEP_PUT_AVG:
                w = '{act: ACT_PUT_AVG, cond: COND_OUT_FREE, target: STEP_IDLE, stay: 1'b1};
            STEP_PUT_EMPTY:
                w = '{act: ACT_PUT_EMPTY, cond: COND_OUT_FREE, target: STEP_IDLE,
                      stay: 1'b1};
            default:
                w = '{act: ACT_NOP, cond: COND_ALWAYS, target: STEP_IDLE, stay: 1'b0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[design/average_pool_window_mean.sv]
// Top level of the average pooling window mean block: feature-map store,
// microcoded sequencer, window clipping, accumulator and serial divider.
// Depends on apw_pkg.
//
//   channel  | direction | handshake            | beat carries
//   ---------+-----------+----------------------+-----------------------------------
//   in       | sink      | in_valid / in_stall  | op, row, col, channel, sample
//   out      | source    | out_valid / out_stall| average, window_empty
//   cfg      | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A load beat goes to the store; the next item is taken in the following cycle.
// A pool beat runs the start, clip, init, read, drain, divide-init, divide and
// output steps: one store read per sample through the single read port, then one
// quotient bit per cycle in the restoring divider. An empty window goes from the
// init step to its output step. Reset clears the sequencer and out_valid and sets
// the configuration to its defaults; the store is not cleared and holds no valid
// bits. While out_stall holds a finished result, input is still taken in the idle
// step; a second pool result waits in its output step until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module average_pool_window_mean #(
    parameter int MAX_HEIGHT   = 32,
    parameter int MAX_WIDTH    = 32,
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_WINDOW   = 8,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // item channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [apw_pkg::OP_W-1:0]             op,
    input  logic [apw_pkg::IDX_W-1:0]            row,
    input  logic [apw_pkg::IDX_W-1:0]            col,
    input  logic [apw_pkg::CH_W-1:0]             channel,
    input  logic signed [apw_pkg::DATA_W-1:0]    sample,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [apw_pkg::DATA_W-1:0]    average,
    output logic                                 window_empty,
    // configuration channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [apw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [apw_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import apw_pkg::*;

    localparam int DEPTH  = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // signed sum of up to MAX_WINDOW^2 samples
    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW * MAX_WINDOW) + 1;
    localparam int EXT_W  = (SUM_W > DATA_W) ? SUM_W : DATA_W;
    localparam int DCNT_W = $clog2(SUM_W);

    // ---------------------------------------------------------------- registers
    logic [PC_W-1:0]          pc_reg, pc_next;

    logic [SIZE_W-1:0]        in_height_reg, in_width_reg;
    logic [WIN_W-1:0]         window_rows_reg, window_cols_reg;
    logic [WIN_W-1:0]         stride_rows_reg, stride_cols_reg;
    logic [PAD_W-1:0]         pad_top_reg, pad_left_reg;

    logic [IDX_W-1:0]         item_row_reg, item_row_next;
    logic [IDX_W-1:0]         item_col_reg, item_col_next;
    logic [CH_W-1:0]          item_ch_reg, item_ch_next;

    logic signed [START_W-1:0] start_r_reg, start_r_next;
    logic signed [START_W-1:0] start_c_reg, start_c_next;
    logic [SIZE_W-1:0]        r_first_reg, r_first_next, r_last_reg, r_last_next;
    logic [SIZE_W-1:0]        c_first_reg, c_first_next, c_last_reg, c_last_next;
    logic [WIN_W-1:0]         nr_reg, nr_next, nc_reg, nc_next;
    logic                     empty_reg, empty_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [SIZE_W-1:0]        cur_r_reg, cur_r_next, cur_c_reg, cur_c_next;

    logic                     rd_pend_reg;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;

    logic [SUM_W-1:0]         quo_reg, quo_next;
    logic [CNT_W-1:0]         rem_reg, rem_next;
    logic                     neg_reg, neg_next;
    logic [DCNT_W-1:0]        div_cnt_reg, div_cnt_next;

    logic                     out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]        average_reg, average_next;
    logic                     window_empty_reg, window_empty_next;

    logic [SAMPLE_BITS-1:0]   store_mem [DEPTH];

    // ---------------------------------------------------------------- control word
    ucode_t uc;
    logic   in_accept;
    logic   out_free;
    logic   at_last;
    logic   cond_hit;

    assign uc        = ucode_rom(pc_reg);
    assign in_stall  = (uc.act != ACT_ACCEPT);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign at_last   = (cur_r_reg == r_last_reg) && (cur_c_reg == c_last_reg);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        unique case (uc.cond)
            COND_NEVER:    cond_hit = 1'b0;
            COND_ALWAYS:   cond_hit = 1'b1;
            COND_POOL:     cond_hit = in_accept && (op == OP_POOL);
            COND_EMPTY:    cond_hit = empty_reg;
            COND_LAST:     cond_hit = at_last;
            COND_DIV_LAST: cond_hit = (div_cnt_reg == '0);
            COND_OUT_FREE: cond_hit = out_free;
            default:       cond_hit = 1'b1;
        endcase

        if (cond_hit)
        begin
            pc_next = uc.target;
        end
        else if (uc.stay)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    // ---------------------------------------------------------------- store ports
    logic                     load_ok;
    logic                     store_we, store_re;
    logic [31:0]              wr_lin, rd_lin;
    logic [ADDR_W-1:0]        wr_addr, rd_addr;
    logic [SAMPLE_BITS+DATA_W-1:0] sample_ext;
    logic [SAMPLE_BITS-1:0]   wr_data;

    assign load_ok  = (32'(row) < MAX_HEIGHT) && (32'(col) < MAX_WIDTH)
                    && (32'(channel) < MAX_CHANNELS);
    assign store_we = in_accept && (op == OP_LOAD) && load_ok;
    assign store_re = (uc.act == ACT_READ);

    assign wr_lin  = (32'(row) * 32'(MAX_WIDTH) + 32'(col)) * 32'(MAX_CHANNELS)
                   + 32'(channel);
    assign rd_lin  = (32'(cur_r_reg) * 32'(MAX_WIDTH) + 32'(cur_c_reg))
                   * 32'(MAX_CHANNELS) + 32'(item_ch_reg);
    assign wr_addr = wr_lin[ADDR_W-1:0];
    assign rd_addr = rd_lin[ADDR_W-1:0];

    // Keep the low SAMPLE_BITS of the field; a wider store zero-fills above it
    assign sample_ext = {{SAMPLE_BITS{1'b0}}, sample};
    assign wr_data    = sample_ext[SAMPLE_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (store_re)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------- window clip
    // Clip one axis: window spans [start, start + win), bounded to [0, size).
    function automatic axis_t clip_axis(
        input logic signed [START_W-1:0] start,
        input logic [WIN_W-1:0]          win,
        input logic [SIZE_W-1:0]         size
    );
        axis_t                   a;
        logic signed [END_W-1:0] s_start, s_end, s_size, s_first, s_last, s_n;
        s_start = END_W'(start);
        s_size  = $signed(END_W'(size));
        s_end   = s_start + $signed(END_W'(win));
        s_first = (s_start < 0) ? '0 : s_start;
        s_last  = (s_end > s_size) ? s_size : s_end;
        s_n     = s_last - s_first;
        a.first = s_first[SIZE_W-1:0];
        a.last  = SIZE_W'(s_last - 1);
        a.n     = (s_last > s_first) ? s_n[WIN_W-1:0] : '0;
        return a;
    endfunction

    logic [PROD_W-1:0]   prod_r, prod_c;
    logic [WIN_W-1:0]    win_r_eff, win_c_eff;
    logic [SIZE_W-1:0]   height_eff, width_eff;
    axis_t               ax_r, ax_c;

    assign prod_r = PROD_W'(item_row_reg) * PROD_W'(stride_rows_reg);
    assign prod_c = PROD_W'(item_col_reg) * PROD_W'(stride_cols_reg);

    // Saturate window to MAX_WINDOW and map size to the store bounds
    assign win_r_eff  = (32'(window_rows_reg) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW)
                                                           : window_rows_reg;
    assign win_c_eff  = (32'(window_cols_reg) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW)
                                                           : window_cols_reg;
    assign height_eff = (32'(in_height_reg) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT)
                                                         : in_height_reg;
    assign width_eff  = (32'(in_width_reg) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH)
                                                       : in_width_reg;

    assign ax_r = clip_axis(start_r_reg, win_r_eff, height_eff);
    assign ax_c = clip_axis(start_c_reg, win_c_eff, width_eff);

    // ---------------------------------------------------------------- datapath
    logic [CNT_W:0]            trial;
    logic                      q_bit;
    logic signed [SUM_W-1:0]   q_signed;
    logic signed [EXT_W-1:0]   q_ext;

    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign q_bit    = (trial >= {1'b0, count_reg});
    assign q_signed = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign q_ext    = EXT_W'(q_signed);

    always_comb
    begin
        item_row_next     = item_row_reg;
        item_col_next     = item_col_reg;
        item_ch_next      = item_ch_reg;
        start_r_next      = start_r_reg;
        start_c_next      = start_c_reg;
        r_first_next      = r_first_reg;
        r_last_next       = r_last_reg;
        c_first_next      = c_first_reg;
        c_last_next       = c_last_reg;
        nr_next           = nr_reg;
        nc_next           = nc_reg;
        empty_next        = empty_reg;
        count_next        = count_reg;
        cur_r_next        = cur_r_reg;
        cur_c_next        = cur_c_reg;
        sum_next          = sum_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        neg_next          = neg_reg;
        div_cnt_next      = div_cnt_reg;
        out_valid_next    = out_valid_reg;
        average_next      = average_reg;
        window_empty_next = window_empty_reg;

        // drop the result once the downstream side takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // add the store word read in the previous cycle
        if (rd_pend_reg)
        begin
            sum_next = sum_reg + SUM_W'(rd_data_reg);
        end

        unique case (uc.act)
            ACT_NOP:
            begin
            end
            ACT_ACCEPT:
            begin
                if (in_accept)
                begin
                    item_row_next = row;
                    item_col_next = col;
                    item_ch_next  = channel;
                end
            end
            ACT_START:
            begin
                start_r_next = $signed({1'b0, prod_r})
                             - $signed({{(START_W - PAD_W){1'b0}}, pad_top_reg});
                start_c_next = $signed({1'b0, prod_c})
                             - $signed({{(START_W - PAD_W){1'b0}}, pad_left_reg});
            end
            ACT_CLIP:
            begin
                r_first_next = ax_r.first;
                r_last_next  = ax_r.last;
                c_first_next = ax_c.first;
                c_last_next  = ax_c.last;
                nr_next      = ax_r.n;
                nc_next      = ax_c.n;
                empty_next   = (32'(item_ch_reg) >= MAX_CHANNELS)
                             || (ax_r.n == '0) || (ax_c.n == '0);
            end
            ACT_INIT:
            begin
                count_next = CNT_W'(nr_reg) * CNT_W'(nc_reg);
                cur_r_next = r_first_reg;
                cur_c_next = c_first_reg;
                sum_next   = '0;
            end
            ACT_READ:
            begin
                // advance across the row, then wrap to the next row
                if (cur_c_reg == c_last_reg)
                begin
                    cur_c_next = c_first_reg;
                    cur_r_next = cur_r_reg + 1'b1;
                end
                else
                begin
                    cur_c_next = cur_c_reg + 1'b1;
                end
            end
            ACT_DIV_INIT:
            begin
                neg_next     = sum_reg[SUM_W-1];
                quo_next     = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
                rem_next     = '0;
                div_cnt_next = DCNT_W'(SUM_W - 1);
            end
            ACT_DIV_STEP:
            begin
                rem_next     = q_bit ? CNT_W'(trial - {1'b0, count_reg}) : trial[CNT_W-1:0];
                quo_next     = {quo_reg[SUM_W-2:0], q_bit};
                div_cnt_next = div_cnt_reg - 1'b1;
            end
            ACT_PUT_AVG:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    average_next      = q_ext[DATA_W-1:0];
                    window_empty_next = 1'b0;
                end
            end
            ACT_PUT_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    average_next      = '0;
                    window_empty_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------- control regs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg          <= STEP_IDLE;
            rd_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            in_height_reg   <= SIZE_W'(32);
            in_width_reg    <= SIZE_W'(32);
            window_rows_reg <= WIN_W'(2);
            window_cols_reg <= WIN_W'(2);
            stride_rows_reg <= WIN_W'(2);
            stride_cols_reg <= WIN_W'(2);
            pad_top_reg     <= '0;
            pad_left_reg    <= '0;
        end
        else
        begin
            pc_reg        <= pc_next;
            rd_pend_reg   <= store_re;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_IN_HEIGHT:   in_height_reg   <= cfg_data[SIZE_W-1:0];
                    CFG_IN_WIDTH:    in_width_reg    <= cfg_data[SIZE_W-1:0];
                    CFG_WINDOW_ROWS: window_rows_reg <= cfg_data[WIN_W-1:0];
                    CFG_WINDOW_COLS: window_cols_reg <= cfg_data[WIN_W-1:0];
                    CFG_STRIDE_ROWS: stride_rows_reg <= cfg_data[WIN_W-1:0];
                    CFG_STRIDE_COLS: stride_cols_reg <= cfg_data[WIN_W-1:0];
                    CFG_PAD_TOP:     pad_top_reg     <= cfg_data[PAD_W-1:0];
                    CFG_PAD_LEFT:    pad_left_reg    <= cfg_data[PAD_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- payload regs
    always_ff @(posedge clk)
    begin
        item_row_reg     <= item_row_next;
        item_col_reg     <= item_col_next;
        item_ch_reg      <= item_ch_next;
        start_r_reg      <= start_r_next;
        start_c_reg      <= start_c_next;
        r_first_reg      <= r_first_next;
        r_last_reg       <= r_last_next;
        c_first_reg      <= c_first_next;
        c_last_reg       <= c_last_next;
        nr_reg           <= nr_next;
        nc_reg           <= nc_next;
        empty_reg        <= empty_next;
        count_reg        <= count_next;
        cur_r_reg        <= cur_r_next;
        cur_c_reg        <= cur_c_next;
        sum_reg          <= sum_next;
        quo_reg          <= quo_next;
        rem_reg          <= rem_next;
        neg_reg          <= neg_next;
        div_cnt_reg      <= div_cnt_next;
        average_reg      <= average_next;
        window_empty_reg <= window_empty_next;
    end

    assign out_valid    = out_valid_reg;
    assign average      = average_reg;
    assign window_empty = window_empty_reg;

endmodule

`default_nettype wire

[design/apw_checker.sv]
// Port-level checker for the average pooling window mean block, with the bind
// that attaches it to the top level. Depends on apw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module apw_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_stall,
    input  wire logic [apw_pkg::OP_W-1:0]          op,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire logic signed [apw_pkg::DATA_W-1:0] average,
    input  wire logic                              window_empty
);
    import apw_pkg::*;

    // hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(average) && $stable(window_empty))
    else $error("stalled result beat changed");

    // an empty window reports a zero mean
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && window_empty |-> average == '0)
    else $error("empty window with nonzero average");

    // a pool beat occupies the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (op == OP_POOL) |=> in_stall)
    else $error("input not stalled after pool beat");

    // a load beat leaves the input open for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (op == OP_LOAD) |=> !in_stall)
    else $error("input stalled after load beat");

endmodule

bind average_pool_window_mean apw_checker u_apw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .average      (average),
    .window_empty (window_empty)
);

`default_nettype wire
